// ----- rtl/core/sogc_pkg.sv -----
// shared types and constants for the segment overlap grid counter
package sogc_pkg;

	// coordinate and total widths
	localparam int COORD_W = 10;
	localparam int TOTAL_W = 21;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// default grid side, in cells
	localparam int GRID_SIDE_DEF = 1024;

	// coverage cell
	localparam int CELL_W = 2;
	localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;
	localparam logic [CELL_W-1:0] CELL_ONCE  = 2'd1;
	localparam logic [CELL_W-1:0] CELL_MULTI = 2'd2;

	// queue depths
	localparam int CMD_DEPTH = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// step direction codes for one coordinate
	localparam logic [1:0] DIR_HOLD = 2'd0;
	localparam logic [1:0] DIR_INC  = 2'd1;
	localparam logic [1:0] DIR_DEC  = 2'd2;

	// classified segment handed from front to back
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [1:0]         dir_x;
		logic [1:0]         dir_y;
		logic [COORD_W-1:0] len;
		logic               rejected;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic [TOTAL_W-1:0] overlap_total;
		logic               rejected;
	} res_t;

endpackage

// ----- rtl/core/sogc_ram.sv -----
// generic single write port ram with registered read
module sogc_ram #(
	parameter int WIDTH  = 2,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port, read returns old data on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/sogc_fifo.sv -----
// small register based first-in first-out queue
module sogc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full,
	output logic [CNT_W-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// status
	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign count   = count_q;
	assign rdata   = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/sogc_front.sv -----
// front end: accepts segments, classifies slope and queues commands
module sogc_front
	import sogc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [COORD_W-1:0] start_x,
	input  logic [COORD_W-1:0] start_y,
	input  logic [COORD_W-1:0] end_x,
	input  logic [COORD_W-1:0] end_y,
	input  logic               clearing,
	output cmd_t               cmd,
	output logic               cmd_valid,
	input  logic               cmd_pop
);

	localparam int CMD_W = $bits(cmd_t);

	logic [COORD_W-1:0] dx;
	logic [COORD_W-1:0] dy;
	cmd_t               cls;
	logic               q_full;
	logic               q_empty;
	logic [CMD_W-1:0]   q_rdata;
	logic [$clog2(CMD_DEPTH + 1)-1:0] q_count;

	// slope classification
	always_comb begin
		dx = (end_x > start_x) ? end_x - start_x : start_x - end_x;
		dy = (end_y > start_y) ? end_y - start_y : start_y - end_y;
		cls.x        = start_x;
		cls.y        = start_y;
		cls.dir_x    = (end_x > start_x) ? DIR_INC : ((end_x < start_x) ? DIR_DEC : DIR_HOLD);
		cls.dir_y    = (end_y > start_y) ? DIR_INC : ((end_y < start_y) ? DIR_DEC : DIR_HOLD);
		cls.len      = (dx > dy) ? dx : dy;
		cls.rejected = !((dx == '0) || (dy == '0) || (dx == dy));
	end

	// no beat taken while the grid is being cleared
	assign full = q_full || clearing;

	// command queue toward the back end
	sogc_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !full),
		.wdata  (cls),
		.pop    (cmd_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full),
		.count  (q_count)
	);

	assign cmd       = cmd_t'(q_rdata);
	assign cmd_valid = !q_empty && (q_count != '0);

endmodule

// ----- rtl/core/sogc_back.sv -----
// back end: clears the grid, walks segment cells and updates coverage
module sogc_back
	import sogc_pkg::*;
#(
	parameter int GRID_SIDE = GRID_SIDE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic                 cmd_valid,
	output logic                 cmd_pop,
	output logic                 clearing,
	input  logic [OUT_CNT_W-1:0] res_count,
	output logic                 res_push,
	output res_t                 res
);

	localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SIDE_W = $clog2(GRID_SIDE) + 1;
	localparam int CMP_W  = (COORD_W > SIDE_W) ? COORD_W : SIDE_W;
	localparam logic [CMP_W-1:0]  SIDE_C    = CMP_W'(GRID_SIDE);
	localparam logic [ADDR_W-1:0] SIDE_A    = ADDR_W'(GRID_SIDE);
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
	localparam int CHK_W = OUT_CNT_W + 1;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;

	// move a coordinate one step along its direction
	function automatic logic [COORD_W-1:0] step_coord(input logic [COORD_W-1:0] c,
		input logic [1:0] dir);
		logic [COORD_W-1:0] r;
		case (dir)
			DIR_INC: r = c + 1'b1;
			DIR_DEC: r = c - 1'b1;
			default: r = c;
		endcase
		return r;
	endfunction

	logic [1:0]         state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [COORD_W-1:0] rem_q;
	logic [1:0]         dir_x_q;
	logic [1:0]         dir_y_q;
	logic               rej_q;

	logic               s1_valid;
	logic               s1_in_grid;
	logic               s1_last;
	logic               s1_rej;
	logic [ADDR_W-1:0]  s1_addr;

	logic               fwd_valid_q;
	logic [ADDR_W-1:0]  fwd_addr_q;
	logic [CELL_W-1:0]  fwd_data_q;
	logic [TOTAL_W-1:0] total_q;

	logic               can_issue;
	logic               issue;
	logic               op_last;
	logic               op_in_grid;
	logic [ADDR_W-1:0]  op_addr;
	logic [CELL_W-1:0]  rd_data;
	logic [CELL_W-1:0]  cur;
	logic [CELL_W-1:0]  new_cell;
	logic               wr_cell;
	logic               inc;
	logic [TOTAL_W-1:0] total_next;

	// issue side: one cell per cycle, held off while the result queue could overflow
	assign can_issue  = (CHK_W'(res_count) + CHK_W'(s1_valid && s1_last)) < CHK_W'(OUT_DEPTH);
	assign issue      = (state_q == ST_WALK) && can_issue;
	assign op_last    = rej_q || (rem_q == '0);
	assign op_in_grid = !rej_q && (CMP_W'(x_q) < SIDE_C) && (CMP_W'(y_q) < SIDE_C);
	assign op_addr    = ADDR_W'(y_q) * SIDE_A + ADDR_W'(x_q);
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid;
	assign clearing   = (state_q == ST_CLEAR);

	// read-modify-write side, with bypass of the write made in the previous cycle
	assign cur        = (fwd_valid_q && (fwd_addr_q == s1_addr)) ? fwd_data_q : rd_data;
	assign wr_cell    = s1_valid && s1_in_grid;
	assign new_cell   = (cur == CELL_EMPTY) ? CELL_ONCE : CELL_MULTI;
	assign inc        = wr_cell && (cur == CELL_ONCE) && (total_q != TOTAL_MAX);
	assign total_next = total_q + TOTAL_W'(inc);

	// result beat after the last cell of a segment
	assign res_push          = s1_valid && s1_last;
	assign res.overlap_total = total_next;
	assign res.rejected      = s1_rej;

	// coverage grid
	sogc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (clearing || wr_cell),
		.waddr (clearing ? clr_q : s1_addr),
		.wdata (clearing ? CELL_EMPTY : new_cell),
		.re    (issue && op_in_grid),
		.raddr (op_addr),
		.rdata (rd_data)
	);

	// sequencer: clearing pass, command load, cell walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (issue && op_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk position
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			x_q     <= cmd.x;
			y_q     <= cmd.y;
			rem_q   <= cmd.len;
			dir_x_q <= cmd.dir_x;
			dir_y_q <= cmd.dir_y;
			rej_q   <= cmd.rejected;
		end else if (issue) begin
			x_q   <= step_coord(x_q, dir_x_q);
			y_q   <= step_coord(y_q, dir_y_q);
			rem_q <= rem_q - 1'b1;
		end
	end

	// cell stage control and overlap total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			fwd_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			s1_valid    <= issue;
			fwd_valid_q <= wr_cell;
			total_q     <= total_next;
		end
	end

	// cell stage payload
	always_ff @(posedge clk) begin
		if (issue) begin
			s1_in_grid <= op_in_grid;
			s1_last    <= op_last;
			s1_rej     <= rej_q;
			s1_addr    <= op_addr;
		end
		fwd_addr_q <= s1_addr;
		fwd_data_q <= new_cell;
	end

endmodule

// ----- rtl/core/segment_overlap_grid_counter.sv -----
// top level of the segment overlap grid counter
//
// Input side is a queue: a segment beat (start_x, start_y, end_x, end_y) is
// taken on a rising edge with push high and full low. Result side is a
// queue too: while empty is low, overlap_total and rejected show the oldest
// result, which leaves on a rising edge with pop high.
// Exactly one result comes out per segment, in order.
// After reset the coverage grid is swept to zero, one cell per cycle, over
// all GRID_SIDE*GRID_SIDE cells (1048576 at the default side); full stays
// high during that pass.
// In the cell walker a segment of length len (the larger coordinate span)
// is loaded from the command queue and then walks its len+1 cells, with
// one grid read-modify-write per cycle while the result queue has room; a
// rejected segment is loaded and then issues one step that touches no cell.
// A result passes the cell stage register, then the result queue register.
// A two-entry command queue in front and a four-entry result queue behind
// let the input and output sides stall independently; when the result
// queue is full the walker pauses and the command queue then fills.
module segment_overlap_grid_counter
	import sogc_pkg::*;
#(
	parameter int GRID_SIDE = GRID_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [COORD_W-1:0] start_x,
	input  logic [COORD_W-1:0] start_y,
	input  logic [COORD_W-1:0] end_x,
	input  logic [COORD_W-1:0] end_y,
	output logic               empty,
	input  logic               pop,
	output logic [TOTAL_W-1:0] overlap_total,
	output logic               rejected
);

	localparam int RES_W = $bits(res_t);

	cmd_t                 cmd;
	logic                 cmd_valid;
	logic                 cmd_pop;
	logic                 clearing;
	logic [OUT_CNT_W-1:0] res_count;
	logic                 res_push;
	res_t                 res;
	logic [RES_W-1:0]     out_data;
	res_t                 out_res;
	logic                 out_full;

	// classify and queue segments
	sogc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.clearing  (clearing),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	// walk cells and count overlaps
	sogc_back #(
		.GRID_SIDE (GRID_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.clearing  (clearing),
		.res_count (res_count),
		.res_push  (res_push),
		.res       (res)
	);

	// result queue
	sogc_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push && !out_full),
		.wdata  (res),
		.pop    (pop && !empty),
		.rdata  (out_data),
		.empty  (empty),
		.full   (out_full),
		.count  (res_count)
	);

	assign out_res       = res_t'(out_data);
	assign overlap_total = out_res.overlap_total;
	assign rejected      = out_res.rejected;

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the segment overlap grid counter
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sogc_pkg::*;

	localparam int GRID_SIDE   = GRID_SIDE_DEF;
	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 2 * GRID_SIDE * GRID_SIDE + 4_000_000;
	localparam int MAX_REPORTS = 10;
	localparam int TAIL_CYCLES = 40;
	localparam int HOT_SPOTS   = 4;

	typedef struct packed {
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y2;
	} seg_t;

	typedef enum int {SEG_HORIZ, SEG_VERT, SEG_DIAG, SEG_SKEW} seg_kind_t;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               push    = 1'b0;
	logic               pop     = 1'b0;
	logic [COORD_W-1:0] start_x = '0;
	logic [COORD_W-1:0] start_y = '0;
	logic [COORD_W-1:0] end_x   = '0;
	logic [COORD_W-1:0] end_y   = '0;
	logic               full;
	logic               empty;
	logic [TOTAL_W-1:0] overlap_total;
	logic               rejected;

	// predicted coverage grid and running total
	bit [CELL_W-1:0]    cov_grid [GRID_SIDE*GRID_SIDE];
	logic [TOTAL_W-1:0] grid_total = '0;
	res_t               expected_results [$];

	int send_idle_pct = 0;
	int rx_stall_pct  = 0;
	int rx_hold_left  = 0;
	int cycle_count   = 0;
	int error_count   = 0;
	int segs_sent     = 0;
	int segs_rejected = 0;
	int results_seen  = 0;
	int hot_x [HOT_SPOTS];
	int hot_y [HOT_SPOTS];

	segment_overlap_grid_counter #(
		.GRID_SIDE(GRID_SIDE)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.empty        (empty),
		.pop          (pop),
		.overlap_total(overlap_total),
		.rejected     (rejected)
	);

	// clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// run watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// one cell of the walk: saturating count, total bumps on 1 -> 2
	function automatic void mark_cell(int x, int y);
		int idx;
		if (x < 0 || y < 0 || x >= GRID_SIDE || y >= GRID_SIDE) return;
		idx = y * GRID_SIDE + x;
		if (cov_grid[idx] == CELL_EMPTY) begin
			cov_grid[idx] = CELL_ONCE;
		end else if (cov_grid[idx] == CELL_ONCE) begin
			cov_grid[idx] = CELL_MULTI;
			if (grid_total != TOTAL_MAX) grid_total = grid_total + 1'b1;
		end
	endfunction

	// rasterize one segment into the predicted grid, return the expected beat
	function automatic res_t rasterize_segment(seg_t s);
		int   x1, y1, x2, y2, dx, dy, sx, sy, len;
		bit   ok;
		res_t r;
		x1 = int'(s.x1);
		y1 = int'(s.y1);
		x2 = int'(s.x2);
		y2 = int'(s.y2);
		dx = (x2 > x1) ? x2 - x1 : x1 - x2;
		dy = (y2 > y1) ? y2 - y1 : y1 - y2;
		sx = (x2 > x1) ? 1 : ((x2 < x1) ? -1 : 0);
		sy = (y2 > y1) ? 1 : ((y2 < y1) ? -1 : 0);
		ok = (dx == 0) || (dy == 0) || (dx == dy);
		if (ok) begin
			len = (dx > dy) ? dx : dy;
			for (int i = 0; i <= len; i++) mark_cell(x1 + i * sx, y1 + i * sy);
		end
		r.overlap_total = grid_total;
		r.rejected      = !ok;
		return r;
	endfunction

	// random segment of a given slope class inside a w x w window
	function automatic seg_t make_segment(seg_kind_t kind, int ox, int oy, int w);
		seg_t s;
		int   x1, y1, x2, y2, lx, ly, len, dx, dy;
		bit   up_x, up_y;
		x1 = ox + $urandom_range(w - 1);
		y1 = oy + $urandom_range(w - 1);
		x2 = ox + $urandom_range(w - 1);
		y2 = oy + $urandom_range(w - 1);
		case (kind)
			SEG_HORIZ: y2 = y1;
			SEG_VERT:  x2 = x1;
			SEG_DIAG: begin
				up_x = 1'($urandom_range(1));
				up_y = 1'($urandom_range(1));
				lx   = up_x ? ox + w - 1 - x1 : x1 - ox;
				ly   = up_y ? oy + w - 1 - y1 : y1 - oy;
				len  = $urandom_range((lx < ly) ? lx : ly);
				x2   = up_x ? x1 + len : x1 - len;
				y2   = up_y ? y1 + len : y1 - len;
			end
			default: begin
				dx = (x2 > x1) ? x2 - x1 : x1 - x2;
				dy = (y2 > y1) ? y2 - y1 : y1 - y2;
				while (dx == 0 || dy == 0 || dx == dy) begin
					x2 = ox + $urandom_range(w - 1);
					y2 = oy + $urandom_range(w - 1);
					dx = (x2 > x1) ? x2 - x1 : x1 - x2;
					dy = (y2 > y1) ? y2 - y1 : y1 - y2;
				end
			end
		endcase
		s.x1 = x1[COORD_W-1:0];
		s.y1 = y1[COORD_W-1:0];
		s.x2 = x2[COORD_W-1:0];
		s.y2 = y2[COORD_W-1:0];
		return s;
	endfunction

	// offer one segment beat, with optional idle gaps, until it is taken
	task automatic send_segment(input seg_t s);
		res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		start_x <= s.x1;
		start_y <= s.y1;
		end_x   <= s.x2;
		end_y   <= s.y2;
		@(posedge clk);
		while (full) @(posedge clk);
		r = rasterize_segment(s);
		expected_results.push_back(r);
		segs_sent++;
		if (r.rejected) segs_rejected++;
	endtask

	task automatic send_coords(input int x1, input int y1, input int x2, input int y2);
		seg_t s;
		s.x1 = x1[COORD_W-1:0];
		s.y1 = y1[COORD_W-1:0];
		s.x2 = x2[COORD_W-1:0];
		s.y2 = y2[COORD_W-1:0];
		send_segment(s);
	endtask

	// stop offering and wait until every predicted beat has come back
	task automatic drain_results();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// result side: check each popped beat, then pick the next pop
	initial begin
		res_t want;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					if (error_count < MAX_REPORTS)
						$display("[%0t] unexpected result beat: total %0d rejected %0b",
							$realtime, overlap_total, rejected);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (overlap_total !== want.overlap_total || rejected !== want.rejected) begin
						if (error_count < MAX_REPORTS)
							$display("[%0t] mismatch: total exp %0d got %0d, rejected exp %0b got %0b",
								$realtime, want.overlap_total, overlap_total,
								want.rejected, rejected);
						error_count++;
					end
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// single cells at three corners, a repeated point
	task automatic test_point_cells();
		send_coords(0, 0, 0, 0);
		send_coords(1023, 1023, 1023, 1023);
		send_coords(0, 0, 0, 0);
		send_coords(1023, 0, 1023, 0);
		drain_results();
	endtask

	// full-length rows and columns in both directions
	task automatic test_full_lines();
		send_coords(0, 0, 1023, 0);
		send_coords(1023, 0, 0, 0);
		send_coords(0, 1023, 0, 0);
		send_coords(1023, 0, 1023, 1023);
		send_coords(0, 1023, 1023, 1023);
		drain_results();
	endtask

	// diagonals walking in all four directions
	task automatic test_diagonal_directions();
		send_coords(0, 0, 1023, 1023);
		send_coords(1023, 0, 0, 1023);
		send_coords(0, 1023, 1023, 0);
		send_coords(1023, 1023, 0, 0);
		send_coords(100, 200, 110, 190);
		send_coords(110, 190, 100, 200);
		send_coords(300, 300, 290, 290);
		send_coords(5, 9, 9, 5);
		drain_results();
	endtask

	// slopes other than flat, upright or 45 degrees leave the total alone
	task automatic test_rejected_slopes();
		send_coords(0, 0, 1023, 1022);
		send_coords(1023, 1023, 0, 1);
		send_coords(512, 512, 513, 514);
		send_coords(0, 1023, 1, 0);
		send_coords(341, 682, 682, 342);
		drain_results();
	endtask

	// random segments clustered around a few hot spots so cells overlap
	task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
		seg_kind_t kind;
		int        w, ox, oy, pick, roll;
		send_idle_pct = idle_pct;
		rx_stall_pct  = stall_pct;
		for (int h = 0; h < HOT_SPOTS; h++) begin
			hot_x[h] = $urandom_range(GRID_SIDE - 48);
			hot_y[h] = $urandom_range(GRID_SIDE - 48);
		end
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < 35)      kind = SEG_HORIZ;
			else if (roll < 60) kind = SEG_VERT;
			else if (roll < 88) kind = SEG_DIAG;
			else                kind = SEG_SKEW;
			if ($urandom_range(49) == 0) begin
				w  = GRID_SIDE;
				ox = 0;
				oy = 0;
			end else begin
				w = 8 + $urandom_range(32);
				if ($urandom_range(9) != 0) begin
					pick = $urandom_range(HOT_SPOTS - 1);
					ox   = hot_x[pick];
					oy   = hot_y[pick];
				end else begin
					ox = $urandom_range(GRID_SIDE - w);
					oy = $urandom_range(GRID_SIDE - w);
				end
			end
			send_segment(make_segment(kind, ox, oy, w));
		end
		drain_results();
	endtask

	// receiver holds off so both queues fill and full backs up the sender
	task automatic test_backpressure();
		int ox, oy;
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		ox = $urandom_range(GRID_SIDE - 16);
		oy = $urandom_range(GRID_SIDE - 16);
		rx_hold_left = 400;
		repeat (24) send_segment(make_segment(seg_kind_t'($urandom_range(3)), ox, oy, 8));
		drain_results();
		repeat (10) send_segment(make_segment(seg_kind_t'($urandom_range(3)), ox, oy, 8));
		drain_results();
	endtask

	// test sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_point_cells();
		test_full_lines();
		test_diagonal_directions();
		test_rejected_slopes();
		test_random_traffic(130, 0, 0);
		test_random_traffic(130, 57, 0);
		test_random_traffic(130, 0, 57);
		test_random_traffic(130, 27, 27);
		test_backpressure();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) error_count++;

		$display("sent %0d segments (%0d with unsupported slope), checked %0d result beats",
			segs_sent, segs_rejected, results_seen);
		$display("final overlap total %0d after %0d cycles, %0d mismatches",
			grid_total, cycle_count, error_count);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
